/* hdl/dqdel_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dqdel_pkg
// Shared types and constants for the double-ended queue with delete by value
// ---------------------------------------------------------------------------
package dqdel_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 4;
    localparam int CNT_W    = 6;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (OCC_W > CNT_W) ? OCC_W : CNT_W;
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CAPACITY);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_POP_FRONT  = 4'd2,
        CMD_POP_BACK   = 4'd3,
        CMD_CLEAR      = 4'd4,
        CMD_DELETE     = 4'd5,
        CMD_DUMP_ALL   = 4'd6,
        CMD_DUMP_FIRST = 4'd7,
        CMD_DUMP_LAST  = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ELEMENT = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    typedef enum logic {
        WM_DUMP,
        WM_DELETE
    } t_walk_mode;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         count;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] element;
        logic                     is_last;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic             busy;
        logic [OCC_W-1:0] occupancy;
    } t_seq_stat;

endpackage

/* hdl/dqdel_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dqdel_ram
// Generic simple dual-port RAM, one write and one registered read port
// ---------------------------------------------------------------------------
module dqdel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/dqdel_seq.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dqdel_seq
// Command sequencer: ring pointers, memory walk for dumps and delete
// ---------------------------------------------------------------------------
module dqdel_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  dqdel_pkg::t_in_item           i_item,
    input  logic [dqdel_pkg::DATA_W-1:0]  i_rdata,
    output dqdel_pkg::t_ram_req           o_ram_req,
    output logic                          o_res_vld,
    output dqdel_pkg::t_out_item          o_res,
    output dqdel_pkg::t_seq_stat          o_stat
);

    dqdel_pkg::t_state                 r_state, n_state;
    dqdel_pkg::t_walk_mode             r_mode, n_mode;
    logic [dqdel_pkg::ADDR_W-1:0]      r_front, n_front;
    logic [dqdel_pkg::OCC_W-1:0]       r_occ, n_occ;
    logic [dqdel_pkg::DATA_W-1:0]      r_val, n_val;
    logic                              r_found, n_found;
    logic [dqdel_pkg::OCC_W-1:0]       r_rpos, n_rpos;
    logic [dqdel_pkg::OCC_W-1:0]       r_rend, n_rend;
    logic                              r_pv, n_pv;
    logic [dqdel_pkg::OCC_W-1:0]       r_ppos, n_ppos;
    logic                              r_plast, n_plast;

    logic [dqdel_pkg::CMP_W-1:0]       w_cnt_x;
    logic [dqdel_pkg::CMP_W-1:0]       w_occ_x;
    logic [dqdel_pkg::OCC_W-1:0]       w_dump_n;
    logic [dqdel_pkg::OCC_W-1:0]       w_dump_first;
    logic                              w_full;
    logic                              w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqdel_pkg::S_IDLE;
            r_front <= '0;
            r_occ   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_occ   <= n_occ;
            r_pv    <= n_pv;
        end
        r_mode  <= n_mode;
        r_val   <= n_val;
        r_found <= n_found;
        r_rpos  <= n_rpos;
        r_rend  <= n_rend;
        r_ppos  <= n_ppos;
        r_plast <= n_plast;
    end

    // dump length clamped to occupancy
    always_comb begin
        w_cnt_x = dqdel_pkg::CMP_W'(i_item.count);
        w_occ_x = dqdel_pkg::CMP_W'(r_occ);
        w_full  = (r_occ == dqdel_pkg::FULL_OCC);
        w_match = (i_rdata == r_val);
        case (i_item.command)
            dqdel_pkg::CMD_DUMP_FIRST: begin
                w_dump_n     = (w_cnt_x > w_occ_x) ? r_occ : dqdel_pkg::OCC_W'(i_item.count);
                w_dump_first = '0;
            end
            dqdel_pkg::CMD_DUMP_LAST: begin
                w_dump_n     = (w_cnt_x > w_occ_x) ? r_occ : dqdel_pkg::OCC_W'(i_item.count);
                w_dump_first = dqdel_pkg::OCC_W'(r_occ - w_dump_n);
            end
            default: begin
                w_dump_n     = r_occ;
                w_dump_first = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_front   = r_front;
        n_occ     = r_occ;
        n_val     = r_val;
        n_found   = r_found;
        n_rpos    = r_rpos;
        n_rend    = r_rend;
        n_pv      = 1'b0;
        n_ppos    = r_ppos;
        n_plast   = r_plast;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_front;
        o_ram_req.wdata = i_item.value;
        o_ram_req.raddr = dqdel_pkg::ADDR_W'(r_front + r_rpos[dqdel_pkg::ADDR_W-1:0]);
        o_res_vld       = 1'b0;
        o_res.status    = dqdel_pkg::ST_ELEMENT;
        o_res.element   = '0;
        o_res.is_last   = 1'b1;

        case (r_state)
            dqdel_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_item.command)
                        dqdel_pkg::CMD_PUSH_FRONT: begin
                            if (w_full) begin
                                o_res_vld    = 1'b1;
                                o_res.status = dqdel_pkg::ST_FULL;
                            end else begin
                                n_front         = dqdel_pkg::ADDR_W'(r_front - 1'b1);
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = dqdel_pkg::ADDR_W'(r_front - 1'b1);
                                n_occ           = dqdel_pkg::OCC_W'(r_occ + 1'b1);
                            end
                        end
                        dqdel_pkg::CMD_PUSH_BACK: begin
                            if (w_full) begin
                                o_res_vld    = 1'b1;
                                o_res.status = dqdel_pkg::ST_FULL;
                            end else begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = dqdel_pkg::ADDR_W'(
                                    r_front + r_occ[dqdel_pkg::ADDR_W-1:0]);
                                n_occ           = dqdel_pkg::OCC_W'(r_occ + 1'b1);
                            end
                        end
                        dqdel_pkg::CMD_POP_FRONT: begin
                            if (r_occ != '0) begin
                                n_front = dqdel_pkg::ADDR_W'(r_front + 1'b1);
                                n_occ   = dqdel_pkg::OCC_W'(r_occ - 1'b1);
                            end
                        end
                        dqdel_pkg::CMD_POP_BACK: begin
                            if (r_occ != '0) begin
                                n_occ = dqdel_pkg::OCC_W'(r_occ - 1'b1);
                            end
                        end
                        dqdel_pkg::CMD_CLEAR: begin
                            n_occ   = '0;
                            n_front = '0;
                        end
                        dqdel_pkg::CMD_DELETE: begin
                            if (r_occ != '0) begin
                                n_state = dqdel_pkg::S_WALK;
                                n_mode  = dqdel_pkg::WM_DELETE;
                                n_val   = i_item.value;
                                n_found = 1'b0;
                                n_rpos  = '0;
                                n_rend  = r_occ;
                            end
                        end
                        dqdel_pkg::CMD_DUMP_ALL, dqdel_pkg::CMD_DUMP_FIRST,
                        dqdel_pkg::CMD_DUMP_LAST: begin
                            if (w_dump_n == '0) begin
                                o_res_vld    = 1'b1;
                                o_res.status = dqdel_pkg::ST_EMPTY;
                            end else begin
                                n_state = dqdel_pkg::S_WALK;
                                n_mode  = dqdel_pkg::WM_DUMP;
                                n_rpos  = w_dump_first;
                                n_rend  = dqdel_pkg::OCC_W'(w_dump_first + w_dump_n);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dqdel_pkg::S_WALK: begin
                // read issue, one position per cycle
                if (r_rpos != r_rend) begin
                    n_pv    = 1'b1;
                    n_ppos  = r_rpos;
                    n_plast = (dqdel_pkg::OCC_W'(r_rpos + 1'b1) == r_rend);
                    n_rpos  = dqdel_pkg::OCC_W'(r_rpos + 1'b1);
                end
                // returned data, from the read issued in the previous cycle
                if (r_pv) begin
                    if (r_mode == dqdel_pkg::WM_DUMP) begin
                        o_res_vld     = 1'b1;
                        o_res.status  = dqdel_pkg::ST_ELEMENT;
                        o_res.element = i_rdata;
                        o_res.is_last = r_plast;
                    end else begin
                        // entries after the match move one place toward the front
                        if (r_found) begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = dqdel_pkg::ADDR_W'(
                                r_front + r_ppos[dqdel_pkg::ADDR_W-1:0] - 1'b1);
                            o_ram_req.wdata = i_rdata;
                        end else if (w_match) begin
                            n_found = 1'b1;
                        end
                        if (r_plast && (r_found || w_match)) begin
                            n_occ = dqdel_pkg::OCC_W'(r_occ - 1'b1);
                        end
                    end
                    if (r_plast) begin
                        n_state = dqdel_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = dqdel_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stat.busy      = (r_state != dqdel_pkg::S_IDLE);
    assign o_stat.occupancy = r_occ;

endmodule

/* hdl/deque_with_delete_by_value.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deque_with_delete_by_value
// Bounded double-ended queue of signed 32-bit values with delete by value
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Push, pop, clear
// and unknown commands leave busy low. Delete by value walks every stored
// element through the entry memory, one read a cycle, or does nothing on an
// empty queue. A dump of n elements gives its results on o_strobe in
// consecutive cycles, front to back, the first one passing through the walk
// state, the memory read and the result register, and the last one marked
// by is_last. An empty dump and a push into a full queue leave busy low and
// give one result, in the cycle after the command. Results are held for one
// cycle only and cannot be stalled. No clearing pass is needed after reset.
module deque_with_delete_by_value (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  dqdel_pkg::t_in_item   i_item,
    output logic                  busy,
    output logic                  o_strobe,
    output dqdel_pkg::t_out_item  o_result
);

    dqdel_pkg::t_ram_req              w_ram_req;
    logic [dqdel_pkg::DATA_W-1:0]     w_rdata;
    logic                             w_res_vld;
    dqdel_pkg::t_out_item             w_res;
    dqdel_pkg::t_seq_stat             w_stat;

    logic                             r_strobe;
    dqdel_pkg::t_out_item             r_result;

    dqdel_ram #(
        .WIDTH (dqdel_pkg::DATA_W),
        .DEPTH (dqdel_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_req.we),
        .i_waddr (w_ram_req.waddr),
        .i_wdata (w_ram_req.wdata),
        .i_raddr (w_ram_req.raddr),
        .o_rdata (w_rdata)
    );

    dqdel_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .i_rdata   (w_rdata),
        .o_ram_req (w_ram_req),
        .o_res_vld (w_res_vld),
        .o_res     (w_res),
        .o_stat    (w_stat)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_res_vld;
        end
        r_result <= w_res;
    end

    assign busy     = w_stat.busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.occupancy <= dqdel_pkg::FULL_OCC)
        else $error("occupancy above capacity");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && w_stat.occupancy == dqdel_pkg::FULL_OCC &&
         (i_item.command == dqdel_pkg::CMD_PUSH_FRONT ||
          i_item.command == dqdel_pkg::CMD_PUSH_BACK))
        |=> (o_strobe && o_result.status == dqdel_pkg::ST_FULL && o_result.is_last))
        else $error("push into full queue not rejected");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && w_stat.occupancy == '0 &&
         (i_item.command == dqdel_pkg::CMD_POP_FRONT ||
          i_item.command == dqdel_pkg::CMD_POP_BACK))
        |=> (!o_strobe && w_stat.occupancy == '0))
        else $error("pop of empty queue changed state");

    a_dump_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.is_last) |=> o_strobe)
        else $error("dump transfer sequence broken");

endmodule
